// File: src/pcm_pkg.sv
package pcm_pkg;

    localparam int LENGTH     = 16;
    localparam int COEF_BITS  = 16;
    localparam int PROD_BITS  = 40;
    localparam int DEG_BITS   = 5;
    localparam int PROD_COUNT = 2 * LENGTH - 1;
    localparam int CNT_BITS   = $clog2(LENGTH);
    localparam int STEP_BITS  = $clog2(PROD_COUNT);

    typedef logic signed [COEF_BITS-1:0] t_coef;
    typedef logic signed [PROD_BITS-1:0] t_prod;
    typedef logic        [DEG_BITS-1:0]  t_deg;

    // control broadcast to every cell
    typedef struct packed {
        logic load;
        logic step;
    } t_cell_ctl;

endpackage

// File: src/pcm_cell.sv
module pcm_cell (
    input  logic              i_clk,
    input  pcm_pkg::t_cell_ctl i_ctl,
    input  pcm_pkg::t_coef    i_a,
    input  pcm_pkg::t_coef    i_b,
    input  pcm_pkg::t_coef    i_x,
    input  pcm_pkg::t_prod    i_sum,
    output pcm_pkg::t_coef    o_a,
    output pcm_pkg::t_coef    o_b,
    output pcm_pkg::t_prod    o_sum,
    output pcm_pkg::t_prod    o_sum_next
);
    import pcm_pkg::*;

    t_coef r_a;
    t_coef r_b;
    t_prod r_sum;
    logic signed [2*COEF_BITS-1:0] w_mul;

    assign w_mul      = r_a * i_x;
    assign o_sum_next = PROD_BITS'(w_mul) + i_sum;
    assign o_a        = r_a;
    assign o_b        = r_b;
    assign o_sum      = r_sum;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a <= i_a;
        end
        if (i_ctl.load || i_ctl.step) begin
            r_b <= i_b;
        end
        // partial sums start from zero for every new polynomial
        if (i_ctl.load) begin
            r_sum <= '0;
        end else if (i_ctl.step) begin
            r_sum <= o_sum_next;
        end
    end

endmodule

// File: src/polynomial_coefficient_multiplier.sv
// Polynomial coefficient multiplier.
// Input channel (i_valid / o_ready): one coefficient pair per item, lowest
// degree first. The LENGTH-th pair completes a polynomial.
// Output channel (o_valid / i_ready): the 2*LENGTH-1 product coefficients,
// lowest degree first, each tagged with o_degree; o_last marks the highest.
// Structure: a row of LENGTH cells, each holding one coefficient of each
// operand. The second operand then shifts down the row, its head broadcast
// to all cells, while partial sums move one cell per unstalled cycle toward
// cell 0 (transposed convolution). Each cell has one multiplier and one adder.
// Timing: a pair is taken every cycle while loading. After the last pair,
// the first product is computed and registered, then one per cycle while
// the receiver does not stall, 2*LENGTH-1 in all; o_ready is low during
// that burst. No new pair is taken until the last product is computed.
// Receiver stall: the output register holds its item and the row freezes
// until i_ready returns. Reset clears the load count, state and o_valid.
module polynomial_coefficient_multiplier (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  pcm_pkg::t_coef  i_a_coef,
    input  pcm_pkg::t_coef  i_b_coef,
    output logic            o_valid,
    input  logic            i_ready,
    output pcm_pkg::t_prod  o_prod_coef,
    output pcm_pkg::t_deg   o_degree,
    output logic            o_last
);
    import pcm_pkg::*;

    localparam logic S_LOAD = 1'b0;
    localparam logic S_CALC = 1'b1;

    logic                 r_state;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [STEP_BITS-1:0] r_step;
    logic                 r_valid;
    t_prod                r_prod;
    t_deg                 r_degree;
    logic                 r_last;

    t_cell_ctl w_ctl;
    logic      w_step_last;
    t_coef     a_chain [LENGTH+1];
    t_coef     b_chain [LENGTH+1];
    t_prod     sum_chain [LENGTH+1];
    t_prod     sum_next [LENGTH];

    always_comb begin
        o_ready     = (r_state == S_LOAD);
        w_ctl.load  = (r_state == S_LOAD) && i_valid;
        w_ctl.step  = (r_state == S_CALC) && (!r_valid || i_ready);
        w_step_last = (r_step == STEP_BITS'(PROD_COUNT - 1));
    end

    assign a_chain[LENGTH]   = i_a_coef;
    // zeros follow the second operand down the row during the burst
    assign b_chain[LENGTH]   = (r_state == S_LOAD) ? i_b_coef : '0;
    assign sum_chain[LENGTH] = '0;

    for (genvar k = 0; k < LENGTH; k++) begin : g_cell
        pcm_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_a        (a_chain[k+1]),
            .i_b        (b_chain[k+1]),
            .i_x        (b_chain[0]),
            .i_sum      (sum_chain[k+1]),
            .o_a        (a_chain[k]),
            .o_b        (b_chain[k]),
            .o_sum      (sum_chain[k]),
            .o_sum_next (sum_next[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_ctl.load) begin
                if (r_cnt == CNT_BITS'(LENGTH - 1)) begin
                    r_cnt   <= '0;
                    r_step  <= '0;
                    r_state <= S_CALC;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (w_ctl.step) begin
                r_valid <= 1'b1;
                r_step  <= r_step + 1'b1;
                if (w_step_last) begin
                    r_state <= S_LOAD;
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.step) begin
            r_prod   <= sum_next[0];
            r_degree <= DEG_BITS'(r_step);
            r_last   <= w_step_last;
        end
    end

    assign o_valid     = r_valid;
    assign o_prod_coef = r_prod;
    assign o_degree    = r_degree;
    assign o_last      = r_last;

endmodule

// File: src/pcm_checker.sv
module pcm_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_ready,
    input logic           o_valid,
    input logic           i_ready,
    input pcm_pkg::t_prod o_prod_coef,
    input pcm_pkg::t_deg  o_degree,
    input logic           o_last
);
    import pcm_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_prod_coef)
            && $stable(o_degree) && $stable(o_last))
        else $error("stalled result changed");

    // no new input while a burst is still in progress
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> !o_ready)
        else $error("input taken during product burst");

    a_last_deg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_degree == DEG_BITS'(PROD_COUNT - 1))
        else $error("last flag on wrong degree");

    a_deg_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> !o_valid
            || o_degree == $past(o_degree) + 1'b1)
        else $error("product degree skipped");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind polynomial_coefficient_multiplier pcm_checker u_pcm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_prod_coef (o_prod_coef),
    .o_degree    (o_degree),
    .o_last      (o_last)
);
